// ===== hw/rtl/kal_pkg.sv =====
package kal_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int POS_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int PACK_W      = (4 * CODE_DIGITS > 16) ? 4 * CODE_DIGITS : 16;
  localparam int PADDR_W     = 3;

  localparam logic [3:0] KEY_HASH = 4'd14;
  localparam logic [3:0] KEY_STAR = 4'd15;

  localparam logic CFG_IDX_TEMP  = 1'b0;
  localparam logic CFG_IDX_LIMIT = 1'b1;

  localparam logic [3:0] FAIL_LIMIT_RST = 4'd3;

  typedef enum logic [1:0] {
    REQ_KEY    = 2'd0,
    REQ_DOOR   = 2'd1,
    REQ_MOTION = 2'd2,
    REQ_LOAD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ALERT_NONE   = 2'd0,
    ALERT_WRONG  = 2'd1,
    ALERT_DOOR   = 2'd2,
    ALERT_MOTION = 2'd3
  } alert_t;

  typedef logic [CODE_DIGITS-1:0][3:0] digits_t;
  typedef logic [CODE_DIGITS-1:0]      mask_t;
  typedef logic [POS_W-1:0]            pos_t;

  typedef struct packed {
    req_t        req_type;
    logic [3:0]  key_code;
    logic        sensor_level;
    logic [15:0] code_value;
  } item_t;

  typedef struct packed {
    logic        armed;
    logic        bolt_closed;
    alert_t      alert_kind;
    logic        door_lamp;
    logic        motion_lamp;
    logic [15:0] entry_digits;
    logic [3:0]  entry_valid;
    logic        code_changed;
    logic [15:0] new_code;
  } res_t;

  // first digit lands in the high nibble, only the low 16 bits are kept
  function automatic logic [15:0] pack_digits(input digits_t d, input mask_t m);
    logic [PACK_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (m[i]) begin
        acc[4*(CODE_DIGITS-1-i) +: 4] = d[i];
      end
    end
    return acc[15:0];
  endfunction

  function automatic digits_t unpack_digits(input logic [15:0] v);
    logic [PACK_W-1:0] wide;
    digits_t           d;
    wide = PACK_W'(v);
    for (int i = 0; i < CODE_DIGITS; i++) begin
      d[i] = wide[4*(CODE_DIGITS-1-i) +: 4];
    end
    return d;
  endfunction

  function automatic logic [3:0] mask_out(input mask_t m);
    logic [PACK_W-1:0] wide;
    wide = PACK_W'(m);
    return wide[3:0];
  endfunction

  function automatic digits_t reset_code();
    digits_t d;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      d[i] = 4'((i + 1) % 16);
    end
    return d;
  endfunction

  function automatic pos_t pos_inc(input pos_t p);
    pos_t r;
    if (p == POS_W'(CODE_DIGITS - 1)) begin
      r = '0;
    end else begin
      r = p + pos_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/kal_cfg.sv =====
module kal_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kal_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [15:0]                temp_code,
  output logic [3:0]                 fail_limit
);
  import kal_pkg::*;

  logic [15:0] temp_code_r;
  logic [3:0]  fail_limit_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_code_r  <= '0;
      fail_limit_r <= FAIL_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        CFG_IDX_TEMP:  temp_code_r  <= pwdata[15:0];
        CFG_IDX_LIMIT: fail_limit_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_IDX_TEMP:  prdata = {16'd0, temp_code_r};
      CFG_IDX_LIMIT: prdata = {28'd0, fail_limit_r};
      default:       prdata = '0;
    endcase
  end

  assign temp_code  = temp_code_r;
  assign fail_limit = fail_limit_r;

endmodule

// ===== hw/rtl/kal_engine.sv =====
module kal_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  kal_pkg::item_t item,
  input  logic [15:0]   temp_code,
  input  logic [3:0]    fail_limit,
  output kal_pkg::res_t res
);
  import kal_pkg::*;

  logic    armed_r, armed_nxt;
  digits_t ring_r, ring_nxt;
  mask_t   emask_r, emask_nxt;
  pos_t    epos_r, epos_nxt;
  logic [3:0] fcount_r, fcount_nxt;
  logic    changing_r, changing_nxt;
  digits_t main_r, main_nxt;
  mask_t   mmask_r, mmask_nxt;
  pos_t    cpos_r, cpos_nxt;
  logic    door_r, door_nxt;
  logic    motion_r, motion_nxt;
  logic    mready_r, mready_nxt;

  alert_t     alert;
  logic       changed;
  logic [3:0] limit;
  logic [3:0] fc_chk;
  digits_t    temp_d;
  logic       main_ok;
  logic       temp_ok;

  assign temp_d = unpack_digits(temp_code);
  assign limit  = (fail_limit == 4'd0) ? 4'd1 : fail_limit;

  // whole-code compare against main and temporary codes
  always_comb begin
    main_ok = 1'b1;
    temp_ok = (temp_code != 16'd0) && (emask_r == '1);
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if ((emask_r[i] != mmask_r[i]) || (emask_r[i] && (ring_r[i] != main_r[i]))) begin
        main_ok = 1'b0;
      end
      if (ring_r[i] != temp_d[i]) begin
        temp_ok = 1'b0;
      end
    end
  end

  always_comb begin
    armed_nxt    = armed_r;
    ring_nxt     = ring_r;
    emask_nxt    = emask_r;
    epos_nxt     = epos_r;
    fcount_nxt   = fcount_r;
    changing_nxt = changing_r;
    main_nxt     = main_r;
    mmask_nxt    = mmask_r;
    cpos_nxt     = cpos_r;
    door_nxt     = door_r;
    motion_nxt   = motion_r;
    mready_nxt   = mready_r;
    alert        = ALERT_NONE;
    changed      = 1'b0;
    fc_chk       = (main_ok || temp_ok) ? 4'd0 : fcount_r + 4'd1;
    case (item.req_type)
      REQ_KEY: begin
        if (item.key_code < KEY_HASH) begin
          ring_nxt[epos_r]  = item.key_code;
          emask_nxt[epos_r] = 1'b1;
          epos_nxt          = pos_inc(epos_r);
          if (!armed_r && changing_r) begin
            main_nxt[cpos_r]  = item.key_code;
            mmask_nxt[cpos_r] = 1'b1;
            cpos_nxt          = pos_inc(cpos_r);
          end
        end else if (armed_r) begin
          if (item.key_code == KEY_STAR) begin
            if (main_ok || temp_ok) begin
              armed_nxt = 1'b0;
            end
            fcount_nxt = fc_chk;
            ring_nxt   = '0;
            emask_nxt  = '0;
            epos_nxt   = '0;
            if (fc_chk >= limit) begin
              alert      = ALERT_WRONG;
              fcount_nxt = 4'd0;
            end
          end
        end else if (changing_r) begin
          if (item.key_code == KEY_STAR) begin
            changing_nxt = 1'b0;
            changed      = 1'b1;
          end
        end else if (item.key_code == KEY_HASH) begin
          if (!door_r) begin
            armed_nxt  = 1'b1;
            mready_nxt = 1'b1;
            if (motion_r) begin
              alert      = ALERT_MOTION;
              mready_nxt = 1'b0;
            end
          end
        end else begin
          changing_nxt = 1'b1;
          mmask_nxt    = '0;
          cpos_nxt     = '0;
          epos_nxt     = '0;
        end
      end
      REQ_DOOR: begin
        if (item.sensor_level && !door_r && armed_r) begin
          alert = ALERT_DOOR;
        end
        door_nxt = item.sensor_level;
      end
      REQ_MOTION: begin
        if (item.sensor_level) begin
          if (armed_r) begin
            motion_nxt = 1'b1;
            if (mready_r) begin
              alert      = ALERT_MOTION;
              mready_nxt = 1'b0;
            end
          end
        end else begin
          motion_nxt = 1'b0;
        end
      end
      REQ_LOAD: begin
        main_nxt  = unpack_digits(item.code_value);
        mmask_nxt = '1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.armed        = armed_nxt;
    res.bolt_closed  = armed_nxt;
    res.alert_kind   = alert;
    res.door_lamp    = armed_nxt && door_nxt;
    res.motion_lamp  = armed_nxt && motion_nxt;
    res.entry_digits = pack_digits(ring_nxt, emask_nxt);
    res.entry_valid  = mask_out(emask_nxt);
    res.code_changed = changed;
    res.new_code     = pack_digits(main_nxt, mmask_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      ring_r     <= '0;
      emask_r    <= '0;
      epos_r     <= '0;
      fcount_r   <= '0;
      changing_r <= 1'b0;
      main_r     <= reset_code();
      mmask_r    <= '1;
      cpos_r     <= '0;
      door_r     <= 1'b0;
      motion_r   <= 1'b0;
      mready_r   <= 1'b0;
    end else if (step) begin
      armed_r    <= armed_nxt;
      ring_r     <= ring_nxt;
      emask_r    <= emask_nxt;
      epos_r     <= epos_nxt;
      fcount_r   <= fcount_nxt;
      changing_r <= changing_nxt;
      main_r     <= main_nxt;
      mmask_r    <= mmask_nxt;
      cpos_r     <= cpos_nxt;
      door_r     <= door_nxt;
      motion_r   <= motion_nxt;
      mready_r   <= mready_nxt;
    end
  end

endmodule

// ===== hw/rtl/keypad_alarm_lock_controller_core.sv =====
// path: an accepted beat is held in the input register until it advances through the
// state update into the result register; throughput: one beat per cycle unless
// out_stall holds a valid result, set by the input register and result register
// reset: synchronous active-low rst_n empties both registers, disarms,
// restores main code 1 2 3 4, temp_code 0 and fail_limit 3
module keypad_alarm_lock_controller_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [3:0]                  in_key_code,
  input  logic                        in_sensor_level,
  input  logic [15:0]                 in_code_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_armed,
  output logic                        out_bolt_closed,
  output logic [1:0]                  out_alert_kind,
  output logic                        out_door_lamp,
  output logic                        out_motion_lamp,
  output logic [15:0]                 out_entry_digits,
  output logic [3:0]                  out_entry_valid,
  output logic                        out_code_changed,
  output logic [15:0]                 out_new_code,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kal_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import kal_pkg::*;

  logic        in_v_r;
  item_t       item_r;
  logic        out_v_r;
  res_t        res_r;
  res_t        res;
  logic        adv;
  logic        in_acc;
  logic [15:0] temp_code;
  logic [3:0]  fail_limit;

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  kal_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .temp_code  (temp_code),
    .fail_limit (fail_limit)
  );

  kal_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .item       (item_r),
    .temp_code  (temp_code),
    .fail_limit (fail_limit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.req_type     <= req_t'(in_req_type);
      item_r.key_code     <= in_key_code;
      item_r.sensor_level <= in_sensor_level;
      item_r.code_value   <= in_code_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_armed        = res_r.armed;
  assign out_bolt_closed  = res_r.bolt_closed;
  assign out_alert_kind   = res_r.alert_kind;
  assign out_door_lamp    = res_r.door_lamp;
  assign out_motion_lamp  = res_r.motion_lamp;
  assign out_entry_digits = res_r.entry_digits;
  assign out_entry_valid  = res_r.entry_valid;
  assign out_code_changed = res_r.code_changed;
  assign out_new_code     = res_r.new_code;

endmodule

// ===== hw/rtl/kal_checker.sv =====
module kal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_armed,
  input logic        out_bolt_closed,
  input logic        out_door_lamp,
  input logic        out_motion_lamp,
  input logic        out_code_changed,
  input logic [15:0] out_entry_digits
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_digits) && $stable(out_armed))
    else $error("stalled result beat changed");

  // bolt drive follows the armed flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bolt_closed == out_armed)
    else $error("bolt drive differs from armed");

  // intrusion lamps only light while armed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_door_lamp || out_motion_lamp) |-> out_armed)
    else $error("lamp lit while open");

  // a code change only commits in the open state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_changed |-> !out_armed)
    else $error("code change committed while armed");

  // no result beat straight after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind keypad_alarm_lock_controller_core kal_checker u_kal_checker (.*);
